### rtl/core/lkw_pkg.sv
// Shared types and constants for the link keepalive watchdog.
// No dependencies; compile before the channel interfaces and the core.
package lkw_pkg;

  localparam int unsigned MsW      = 16;  // silence, interval and limit counters
  localparam int unsigned ElapsedW = 8;   // milliseconds carried by one tick
  localparam int unsigned InvW     = 8;   // invalid-message counter and limit
  localparam int unsigned CfgIdxW  = 2;   // configuration register index
  localparam int unsigned CfgDataW = 16;  // configuration write data

  localparam logic [MsW-1:0]  TimeoutLimitRst  = 16'd60000;
  localparam logic [MsW-1:0]  KeepaliveStartRst = 16'd30000;
  localparam logic [MsW-1:0]  KeepaliveIntvRst = 16'd2000;
  localparam logic [InvW-1:0] InvalidLimitRst  = 8'd10;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_VALID   = 2'd1,
    OP_INVALID = 2'd2,
    OP_CLEAR   = 2'd3
  } lkw_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT_LIMIT   = 2'd0,
    REG_KEEPALIVE_START = 2'd1,
    REG_KEEPALIVE_INTV  = 2'd2,
    REG_INVALID_LIMIT   = 2'd3
  } lkw_reg_e;

endpackage

### rtl/core/lkw_if.sv
// Valid/ready channel interfaces: event words in, status words out, config writes.
// Depends on lkw_pkg for field widths and the opcode type.
interface lkw_in_if import lkw_pkg::*; ();
  logic                valid;
  logic                ready;
  lkw_op_e             opcode;
  logic [ElapsedW-1:0] elapsed_ms;
  logic                supervise_enable;

  modport source (output valid, opcode, elapsed_ms, supervise_enable, input ready);
  modport sink   (input valid, opcode, elapsed_ms, supervise_enable, output ready);
endinterface

interface lkw_out_if import lkw_pkg::*; ();
  logic valid;
  logic ready;
  logic send_keepalive;
  logic timeout_fault;
  logic link_fault;

  modport source (output valid, send_keepalive, timeout_fault, link_fault, input ready);
  modport sink   (input valid, send_keepalive, timeout_fault, link_fault, output ready);
endinterface

interface lkw_cfg_if import lkw_pkg::*; ();
  logic                valid;
  logic                ready;
  lkw_reg_e            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/link_keepalive_watchdog.sv
// Link keepalive watchdog: supervises silence on a serial link, requests keepalives
// and flags timeout and link faults. Depends on lkw_pkg and the lkw_*_if interfaces.
//
// Flow: an accepted event word is captured in the input register and moves on into the
// result register at hand-off; its status word sits on out_o until it is taken.
// Throughput: one event word per cycle while out_o keeps taking status words; the state
// update is one add-and-compare pass between the input and result registers.
// Reset: rst_ni clears silence, interval and invalid counters, empties both stages and
// loads the configuration registers with their default values.
module link_keepalive_watchdog import lkw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lkw_in_if.sink    in_i,
  lkw_out_if.source out_o,
  lkw_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [MsW-1:0]  timeout_limit_q, keepalive_start_q, keepalive_intv_q;
  logic [InvW-1:0] invalid_limit_q;

  // Watchdog state
  logic [MsW-1:0]  silence_q, silence_d;
  logic [MsW-1:0]  ka_cnt_q, ka_cnt_d;
  logic [InvW-1:0] inv_cnt_q, inv_cnt_d;

  // Input stage
  logic                s1_valid_q;
  lkw_op_e             s1_op_q;
  logic [ElapsedW-1:0] s1_elapsed_q;
  logic                s1_enable_q;

  // Result stage
  logic out_valid_q;
  logic ka_q, tof_q, lf_q;
  logic ka_d, tof_d, lf_d;

  logic in_fire, s1_fire;

  // The configuration port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_limit_q   <= TimeoutLimitRst;
      keepalive_start_q <= KeepaliveStartRst;
      keepalive_intv_q  <= KeepaliveIntvRst;
      invalid_limit_q   <= InvalidLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TIMEOUT_LIMIT:   timeout_limit_q   <= cfg_i.data;
        REG_KEEPALIVE_START: keepalive_start_q <= cfg_i.data;
        REG_KEEPALIVE_INTV:  keepalive_intv_q  <= cfg_i.data;
        REG_INVALID_LIMIT:   invalid_limit_q   <= cfg_i.data[InvW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage hands its word on whenever the result register is empty
  // or being drained this cycle, so a new word can enter every cycle unless out_o stalls.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload of the input stage: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q      <= in_i.opcode;
      s1_elapsed_q <= in_i.elapsed_ms;
      s1_enable_q  <= in_i.supervise_enable;
    end
  end

  // Single-pass update. Silence and interval sums are independent adds, each
  // saturated to 16 bits, followed by their compares.
  logic [MsW:0]    sil_sum, ka_sum;
  logic [MsW-1:0]  sil_sat, ka_sat;
  logic [InvW:0]   inv_next;

  always_comb begin
    sil_sum  = {1'b0, silence_q} + {{(MsW+1-ElapsedW){1'b0}}, s1_elapsed_q};
    ka_sum   = {1'b0, ka_cnt_q}  + {{(MsW+1-ElapsedW){1'b0}}, s1_elapsed_q};
    sil_sat  = sil_sum[MsW] ? {MsW{1'b1}} : sil_sum[MsW-1:0];
    ka_sat   = ka_sum[MsW]  ? {MsW{1'b1}} : ka_sum[MsW-1:0];
    inv_next = {1'b0, inv_cnt_q} + {{InvW{1'b0}}, 1'b1};

    silence_d = silence_q;
    ka_cnt_d  = ka_cnt_q;
    inv_cnt_d = inv_cnt_q;
    ka_d      = 1'b0;
    tof_d     = 1'b0;
    lf_d      = 1'b0;

    case (s1_op_q)
      OP_TICK: begin
        if (s1_enable_q) begin
          if (silence_q < timeout_limit_q) begin
            silence_d = sil_sat;
            if (sil_sat > keepalive_start_q) begin
              // An interval of zero pulses on every tick past the start level.
              if (ka_sat >= keepalive_intv_q) begin
                ka_d     = 1'b1;
                ka_cnt_d = '0;
              end else begin
                ka_cnt_d = ka_sat;
              end
            end else begin
              ka_cnt_d = '0;
            end
          end else begin
            // Clamp silence at the limit and raise the fault on every further tick.
            tof_d     = 1'b1;
            silence_d = timeout_limit_q;
          end
        end
      end
      OP_VALID: begin
        silence_d = '0;
        inv_cnt_d = '0;
      end
      OP_INVALID: begin
        // Nine-bit compare so a limit of 255 still saturates.
        if (inv_next > {1'b0, invalid_limit_q}) begin
          inv_cnt_d = invalid_limit_q;
          lf_d      = 1'b1;
        end else begin
          inv_cnt_d = inv_next[InvW-1:0];
        end
      end
      OP_CLEAR: begin
        silence_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= '0;
      ka_cnt_q  <= '0;
      inv_cnt_q <= '0;
    end else if (s1_fire) begin
      silence_q <= silence_d;
      ka_cnt_q  <= ka_cnt_d;
      inv_cnt_q <= inv_cnt_d;
    end
  end

  // Result register: load on hand-off, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ka_q  <= ka_d;
      tof_q <= tof_d;
      lf_q  <= lf_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.send_keepalive = ka_q;
  assign out_o.timeout_fault  = tof_q;
  assign out_o.link_fault     = lf_q;

  // A status word raises at most one flag.
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> $countones({ka_d, tof_d, lf_d}) <= 1)
    else $error("more than one status flag in one word");

  // A keepalive request restarts the interval count.
  a_ka_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ka_d |=> ka_cnt_q == '0)
    else $error("interval counter not cleared after keepalive");

  // A timeout fault leaves silence clamped at the limit.
  a_tof_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && tof_d |=> silence_q == $past(timeout_limit_q))
    else $error("silence not clamped after timeout fault");

  // A link fault leaves the invalid count saturated at its limit.
  a_lf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && lf_d |=> inv_cnt_q == $past(invalid_limit_q))
    else $error("invalid count not saturated after link fault");

  // Every hand-off from the input stage shows up as a pending result.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("result lost at hand-off");

endmodule

### bench/link_keepalive_watchdog_test.sv
`timescale 1ns / 1ps
// Self-checking bench for link_keepalive_watchdog: drives event words, predicts each status
// word and compares it field by field. Depends on lkw_pkg, the lkw_*_if interfaces and the core.
module link_keepalive_watchdog_test;
  import lkw_pkg::*;

  localparam int StallLimit = 4000;  // cycles without any handshake before giving up
  localparam int ShowLimit  = 10;    // mismatches printed in full

  typedef struct packed {
    lkw_op_e             op;
    logic [ElapsedW-1:0] elapsed_ms;
    logic                supervise;
  } event_word_t;

  typedef struct packed {
    logic keepalive;
    logic timeout;
    logic link;
  } status_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lkw_in_if  in_if ();
  lkw_out_if out_if ();
  lkw_cfg_if cfg_if ();

  link_keepalive_watchdog dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the watchdog: register file and the three counters.
  logic [MsW-1:0]  shadow_reg [4];
  logic [MsW-1:0]  silence_ms   = '0;
  logic [MsW-1:0]  interval_acc = '0;
  logic [InvW-1:0] invalid_seen = '0;

  event_word_t  event_backlog [$];  // words waiting to be offered to the block
  status_word_t status_due    [$];  // predicted status words, oldest first

  int  words_sent, words_taken, words_checked;
  int  mismatches, settings_used;
  int  keepalives_seen, timeouts_seen, link_faults_seen;
  int  quiet_cycles;
  int  in_gap, out_gap;
  bit  calm;  // no idling on either side once set

  initial begin
    shadow_reg[REG_TIMEOUT_LIMIT]   = TimeoutLimitRst;
    shadow_reg[REG_KEEPALIVE_START] = KeepaliveStartRst;
    shadow_reg[REG_KEEPALIVE_INTV]  = KeepaliveIntvRst;
    shadow_reg[REG_INVALID_LIMIT]   = {{(MsW-InvW){1'b0}}, InvalidLimitRst};
  end

  // Advance the shadow state by one event word and return the status it raises.
  function automatic status_word_t status_for_event(event_word_t w);
    status_word_t    s;
    logic [MsW:0]    sum;
    logic [InvW:0]   next_count;
    logic [InvW-1:0] inv_limit;
    s = '0;
    inv_limit = shadow_reg[REG_INVALID_LIMIT][InvW-1:0];
    case (w.op)
      OP_TICK: begin
        // a tick with supervision off leaves everything alone
        if (w.supervise) begin
          if (silence_ms < shadow_reg[REG_TIMEOUT_LIMIT]) begin
            sum = {1'b0, silence_ms} + {{(MsW+1-ElapsedW){1'b0}}, w.elapsed_ms};
            silence_ms = sum[MsW] ? '1 : sum[MsW-1:0];
            if (silence_ms > shadow_reg[REG_KEEPALIVE_START]) begin
              sum = {1'b0, interval_acc} + {{(MsW+1-ElapsedW){1'b0}}, w.elapsed_ms};
              interval_acc = sum[MsW] ? '1 : sum[MsW-1:0];
              // an interval of zero fires on every tick past the start level
              if (interval_acc >= shadow_reg[REG_KEEPALIVE_INTV]) begin
                s.keepalive = 1'b1;
                interval_acc = '0;
              end
            end else begin
              interval_acc = '0;
            end
          end else begin
            // at or past the limit: flag and clamp silence
            s.timeout = 1'b1;
            silence_ms = shadow_reg[REG_TIMEOUT_LIMIT];
          end
        end
      end
      OP_VALID: begin
        // interval counter deliberately survives a valid message
        silence_ms = '0;
        invalid_seen = '0;
      end
      OP_INVALID: begin
        // count in one extra bit so a limit of 255 still saturates
        next_count = {1'b0, invalid_seen} + {{InvW{1'b0}}, 1'b1};
        if (next_count > {1'b0, inv_limit}) begin
          invalid_seen = inv_limit;
          s.link = 1'b1;
        end else begin
          invalid_seen = next_count[InvW-1:0];
        end
      end
      OP_CLEAR: begin
        silence_ms = '0;
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  function automatic event_word_t random_event(int wt, int wv, int wi, int wc, int el_lo,
                                               int en_pct);
    event_word_t w;
    int          pick;
    pick = $urandom_range(0, wt + wv + wi + wc - 1);
    if (pick < wt) w.op = OP_TICK;
    else if (pick < wt + wv) w.op = OP_VALID;
    else if (pick < wt + wv + wi) w.op = OP_INVALID;
    else w.op = OP_CLEAR;
    if (w.op == OP_TICK) begin
      w.elapsed_ms = ElapsedW'($urandom_range(el_lo, 255));
      w.supervise  = ($urandom_range(0, 99) < en_pct);
    end else begin
      // fields the block ignores still get random values
      w.elapsed_ms = ElapsedW'($urandom_range(0, 255));
      w.supervise  = 1'($urandom_range(0, 1));
    end
    return w;
  endfunction

  function automatic event_word_t make_event(lkw_op_e op, int el, bit en);
    event_word_t w;
    w.op = op;
    w.elapsed_ms = ElapsedW'(el);
    w.supervise = en;
    return w;
  endfunction

  // Event driver: offer the next backlog word at the falling edge, hold it until taken,
  // then drop valid for a random burst now and then.
  always @(negedge clk_i) begin
    event_word_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (words_sent == words_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
        w = event_backlog.pop_front();
        in_if.opcode <= w.op;
        in_if.elapsed_ms <= w.elapsed_ms;
        in_if.supervise_enable <= w.supervise;
        in_if.valid <= 1'b1;
        words_sent = words_sent + 1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: drop ready for bursts of random length now and then.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 9);
    end
  end

  // Predict on every accepted event word and check every accepted status word.
  always @(posedge clk_i) begin
    event_word_t  w;
    status_word_t got, want;
    if (in_if.valid && in_if.ready) begin
      w.op = in_if.opcode;
      w.elapsed_ms = in_if.elapsed_ms;
      w.supervise = in_if.supervise_enable;
      status_due.push_back(status_for_event(w));
      words_taken = words_taken + 1;
    end
    if (out_if.valid && out_if.ready) begin
      got.keepalive = out_if.send_keepalive;
      got.timeout = out_if.timeout_fault;
      got.link = out_if.link_fault;
      if (got.keepalive) keepalives_seen = keepalives_seen + 1;
      if (got.timeout) timeouts_seen = timeouts_seen + 1;
      if (got.link) link_faults_seen = link_faults_seen + 1;
      if (status_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= ShowLimit)
          $display("[%0t] status word with nothing expected: keepalive=%b timeout=%b link=%b",
                   $realtime, got.keepalive, got.timeout, got.link);
      end else begin
        want = status_due.pop_front();
        if (got.keepalive !== want.keepalive || got.timeout !== want.timeout ||
            got.link !== want.link) begin
          mismatches = mismatches + 1;
          if (mismatches <= ShowLimit)
            $display({"[%0t] status word %0d: expected keepalive=%b timeout=%b link=%b,",
                      " got %b %b %b"},
                     $realtime, words_checked, want.keepalive, want.timeout, want.link,
                     got.keepalive, got.timeout, got.link);
        end
        words_checked = words_checked + 1;
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, StallLimit);
        $display("link_keepalive_watchdog_test failed");
        $finish;
      end
    end
  end

  // Wait until every backlog word is taken and every status word has come back, then let
  // the two-stage pipe run dry.
  task automatic settle();
    while (event_backlog.size() != 0 || words_sent != words_taken || status_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while the block is idle.
  task automatic write_settings(input logic [MsW-1:0] limit, input logic [MsW-1:0] start,
                                input logic [MsW-1:0] intv, input logic [MsW-1:0] inv);
    lkw_reg_e       r;
    logic [MsW-1:0] d;
    r = REG_TIMEOUT_LIMIT;
    repeat (4) begin
      case (r)
        REG_TIMEOUT_LIMIT:   d = limit;
        REG_KEEPALIVE_START: d = start;
        REG_KEEPALIVE_INTV:  d = intv;
        default:             d = inv;
      endcase
      @(negedge clk_i);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= r;
      cfg_if.data <= d;
      do @(posedge clk_i); while (!cfg_if.ready);
      shadow_reg[r] = (r == REG_INVALID_LIMIT) ? {{(MsW-InvW){1'b0}}, d[InvW-1:0]} : d;
      r = r.next();
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    settings_used = settings_used + 1;
  endtask

  // One random phase: settle, load a setting, then queue words with the given op mix.
  task automatic run_phase(input logic [MsW-1:0] limit, input logic [MsW-1:0] start,
                           input logic [MsW-1:0] intv, input logic [MsW-1:0] inv, int count,
                           int wt, int wv, int wi, int wc, int el_lo, int en_pct);
    settle();
    write_settings(limit, start, intv, inv);
    repeat (count) event_backlog.push_back(random_event(wt, wv, wi, wc, el_lo, en_pct));
  endtask

  initial begin
    logic [MsW-1:0] rl, rs;
    // every input known from time zero
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_TICK;
    in_if.elapsed_ms = '0;
    in_if.supervise_enable = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TIMEOUT_LIMIT;
    cfg_if.data = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: disabled tick, zero and full elapsed, every op at least once.
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b0));
    event_backlog.push_back(make_event(OP_TICK, 0, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b1));
    event_backlog.push_back(make_event(OP_VALID, 90, 1'b1));
    event_backlog.push_back(make_event(OP_INVALID, 0, 1'b0));
    event_backlog.push_back(make_event(OP_CLEAR, 255, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 128, 1'b1));
    settle();

    // Directed, tight setting: invalid limit zero faults at once, interval one pulses on
    // every tick past the start level, then timeout with clamp, disabled tick and clear.
    write_settings(16'd600, 16'd300, 16'd1, 16'd0);
    event_backlog.push_back(make_event(OP_INVALID, 0, 1'b1));
    event_backlog.push_back(make_event(OP_INVALID, 255, 1'b0));
    event_backlog.push_back(make_event(OP_VALID, 0, 1'b0));
    event_backlog.push_back(make_event(OP_INVALID, 0, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 0, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b0));
    event_backlog.push_back(make_event(OP_CLEAR, 0, 1'b1));
    event_backlog.push_back(make_event(OP_TICK, 255, 1'b1));

    // Reset values again, long silent run: keepalives from 30000 ms, then timeouts.
    run_phase(TimeoutLimitRst, KeepaliveStartRst, KeepaliveIntvRst,
              {{(MsW-InvW){1'b0}}, InvalidLimitRst}, 300, 96, 0, 4, 0, 240, 98);
    // All limits at the bottom: every enabled tick times out, every invalid faults.
    run_phase(16'd0, 16'd0, 16'd1, 16'd0, 80, 40, 20, 30, 10, 0, 80);
    // Top limits: the interval counter runs across valid messages until it saturates.
    run_phase(16'd65280, 16'd0, 16'd65535, 16'd254, 280, 97, 2, 1, 0, 250, 98);
    // Interval zero and invalid limit 255: mostly invalid words to push the count to the top.
    run_phase(16'd1000, 16'd500, 16'd0, 16'd255, 310, 10, 0, 88, 2, 0, 85);
    // Start level above the timeout limit: keepalive never fires.
    run_phase(16'd200, 16'd65280, 16'd1, 16'd254, 60, 50, 15, 20, 15, 0, 80);
    // Random moderate settings, mixed traffic.
    rl = MsW'($urandom_range(0, 3000));
    rs = MsW'($urandom_range(0, rl));
    run_phase(rl, rs, MsW'($urandom_range(1, 800)), MsW'($urandom_range(0, 20)),
              80, 55, 15, 20, 10, 0, 85);
    // Last stretch: fresh random setting with no idling on either side.
    rl = MsW'($urandom_range(0, 3000));
    rs = MsW'($urandom_range(0, rl));
    settle();
    calm = 1'b1;
    run_phase(rl, rs, MsW'($urandom_range(1, 800)), MsW'($urandom_range(0, 20)),
              100, 55, 15, 20, 10, 0, 85);

    settle();
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) mismatches = mismatches + status_due.size();

    $display("covered %0d event words under %0d register settings", words_taken, settings_used);
    $display("saw %0d keepalive requests, %0d timeout faults, %0d link faults, %0d mismatches",
             keepalives_seen, timeouts_seen, link_faults_seen, mismatches);
    if (mismatches == 0) begin
      $display("link_keepalive_watchdog_test passed");
    end else begin
      $display("link_keepalive_watchdog_test failed");
    end
    $finish;
  end

endmodule
